@@ rtl/core/ssp_pkg.sv @@
// ssp_pkg: shared types and constants of the shortest-path core.
// No dependencies; used by every module in rtl/core.
package ssp_pkg;

  localparam int unsigned NODE_W   = 11;
  localparam int unsigned WEIGHT_W = 30;
  localparam int unsigned DIST_W   = 31;

  localparam logic [DIST_W-1:0] UNREACH = 31'h7fff_ffff;

  // operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // configuration register indexes
  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_SOURCE     = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_RUN,
    KIND_READ,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   query_node;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_e               kind;
    logic                bad;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   query_node;
  } task_t;

endpackage

@@ rtl/core/single_source_shortest_path_core.sv @@
// Shortest-path core: edge load, Dijkstra run, distance read.
// Add edge and read distance: the result waits on the registered edge-head or
// distance memory read (range errors, a full table and unknown operations skip
// it); the back end takes the next item only once the last result is registered.
// A run clears all distances, then pops the heap, sifting down one level per pass,
// and relaxes each outgoing edge. After reset a clearing pass runs first.
module single_source_shortest_path_core #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [ssp_pkg::NODE_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ssp_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ssp_pkg::result_t           out_result_o
);

  logic [ssp_pkg::NODE_W-1:0] node_count_q, source_node_q;
  logic                       init_busy, task_valid, task_ready;
  ssp_pkg::task_t             task_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= ssp_pkg::NODE_W'(1);
      source_node_q <= ssp_pkg::NODE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ssp_pkg::CFG_NODE_COUNT: node_count_q  <= cfg_data_i;
        ssp_pkg::CFG_SOURCE:     source_node_q <= cfg_data_i;
        default:                 node_count_q  <= node_count_q;
      endcase
    end
  end

  ssp_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .node_count_i (node_count_q),
    .source_node_i(source_node_q),
    .init_busy_i  (init_busy),
    .task_valid_o (task_valid),
    .task_ready_i (task_ready),
    .task_o       (task_item)
  );

  ssp_back #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .source_node_i(source_node_q),
    .init_busy_o  (init_busy),
    .task_valid_i (task_valid),
    .task_ready_o (task_ready),
    .task_i       (task_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (out_result_o)
  );

endmodule

@@ rtl/core/ssp_front.sv @@
// ssp_front: accepts input items, classifies them and queues them (two entries).
// Depends on ssp_pkg.
module ssp_front #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ssp_pkg::in_item_t           in_item_i,
  input  logic [ssp_pkg::NODE_W-1:0]  node_count_i,
  input  logic [ssp_pkg::NODE_W-1:0]  source_node_i,
  input  logic                        init_busy_i,
  output logic                        task_valid_o,
  input  logic                        task_ready_i,
  output ssp_pkg::task_t              task_o
);

  ssp_pkg::task_t fifo_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  ssp_pkg::task_t cls;
  logic [31:0]    n_eff;
  logic           push, pop;

  // effective node count
  assign n_eff = (32'(node_count_i) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(node_count_i);

  // classify the incoming item
  always_comb begin
    cls.from_node  = in_item_i.from_node;
    cls.to_node    = in_item_i.to_node;
    cls.weight     = in_item_i.weight;
    cls.query_node = in_item_i.query_node;
    cls.kind       = ssp_pkg::KIND_NOP;
    cls.bad        = 1'b0;
    unique case (in_item_i.operation)
      ssp_pkg::OP_ADD: begin
        cls.kind = ssp_pkg::KIND_ADD;
        cls.bad  = (in_item_i.from_node == '0) || (in_item_i.to_node == '0) ||
                   (32'(in_item_i.from_node) > 32'(MAX_NODES)) ||
                   (32'(in_item_i.to_node) > 32'(MAX_NODES));
      end
      ssp_pkg::OP_RUN: begin
        cls.kind = ssp_pkg::KIND_RUN;
        cls.bad  = (n_eff == '0) || (source_node_i == '0) ||
                   (32'(source_node_i) > n_eff);
      end
      ssp_pkg::OP_READ: begin
        cls.kind = ssp_pkg::KIND_READ;
        cls.bad  = (in_item_i.query_node == '0) ||
                   (32'(in_item_i.query_node) > n_eff);
      end
      default: begin
        cls.kind = ssp_pkg::KIND_NOP;
      end
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2) && !init_busy_i;
  assign push         = in_valid_i && in_ready_o;
  assign task_valid_o = (cnt_q != 2'd0);
  assign pop          = task_valid_o && task_ready_i;
  assign task_o       = fifo_q[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/core/ssp_back.sv @@
// ssp_back: sequencer that executes classified items: edge table, distance
// store and binary heap memories, result register. Depends on ssp_pkg.
module ssp_back #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ssp_pkg::NODE_W-1:0]  node_count_i,
  input  logic [ssp_pkg::NODE_W-1:0]  source_node_i,
  output logic                        init_busy_o,
  input  logic                        task_valid_i,
  output logic                        task_ready_o,
  input  ssp_pkg::task_t              task_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ssp_pkg::result_t            out_result_o
);

  localparam int unsigned NIW = $clog2(MAX_NODES + 1);
  localparam int unsigned EIW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned HD  = MAX_EDGES + 1;
  localparam int unsigned HAW = $clog2(HD);
  localparam int unsigned HIW = $clog2(HD + 1);
  localparam int unsigned XW  = HIW + 1;
  localparam int unsigned NW  = ssp_pkg::NODE_W;
  localparam int unsigned DW  = ssp_pkg::DIST_W;
  localparam int unsigned WW  = ssp_pkg::WEIGHT_W;
  localparam logic [EIW-1:0] NULL_EDGE = EIW'(MAX_EDGES);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_ADD_WR  = 5'd2;
  localparam logic [4:0] S_READ_WB = 5'd3;
  localparam logic [4:0] S_CLR     = 5'd4;
  localparam logic [4:0] S_SRC     = 5'd5;
  localparam logic [4:0] S_POP0    = 5'd6;
  localparam logic [4:0] S_POP1    = 5'd7;
  localparam logic [4:0] S_POP2    = 5'd8;
  localparam logic [4:0] S_SD0     = 5'd9;
  localparam logic [4:0] S_SD1     = 5'd10;
  localparam logic [4:0] S_SD2     = 5'd11;
  localparam logic [4:0] S_SET_RD  = 5'd12;
  localparam logic [4:0] S_SET_CHK = 5'd13;
  localparam logic [4:0] S_FE      = 5'd14;
  localparam logic [4:0] S_EDGE    = 5'd15;
  localparam logic [4:0] S_DST     = 5'd16;
  localparam logic [4:0] S_PU0     = 5'd17;
  localparam logic [4:0] S_PU1     = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  typedef struct packed {
    logic [NW-1:0]  target;
    logic [WW-1:0]  length;
    logic [EIW-1:0] link;
  } edge_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] dval;
  } dist_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [DW-1:0] key;
  } heap_t;

  // memories
  logic [EIW-1:0] fe_mem   [MAX_NODES+1];
  dist_t          dist_mem [MAX_NODES+1];
  edge_t          edge_mem [MAX_EDGES];
  heap_t          heap_mem [HD];

  logic           fe_we, dist_we, edge_we, heap_we;
  logic [NIW-1:0] fe_wa, fe_ra, dist_wa, dist_ra;
  logic [EIW-1:0] fe_wd, fe_rd;
  dist_t          dist_wd, dist_rd;
  logic [EAW-1:0] edge_wa, edge_ra;
  edge_t          edge_wd, edge_rd;
  logic [HAW-1:0] heap_wa, heap_ra;
  heap_t          heap_wd, heap_rd;

  always_ff @(posedge clk_i) begin
    if (fe_we) fe_mem[fe_wa] <= fe_wd;
    fe_rd <= fe_mem[fe_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_rd <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_rd <= heap_mem[heap_ra];
  end

  // control and working registers
  logic [4:0]     st_q, st_d;
  logic [NIW-1:0] cnt_q, cnt_d;
  ssp_pkg::task_t task_q, task_d;
  logic [EIW-1:0] ecount_q, ecount_d;
  logic [HIW-1:0] hsize_q, hsize_d;
  logic [HAW-1:0] hi_q, hi_d;
  logic [NW-1:0]  top_q, top_d;
  heap_t          cur_q, cur_d;
  heap_t          lch_q, lch_d;
  logic [DW-1:0]  du_q, du_d;
  logic [EIW-1:0] link_q, link_d;
  logic [DW-1:0]  sum_q, sum_d;
  logic [NW-1:0]  v_q, v_d;
  ssp_pkg::result_t res_q, res_d;
  logic           out_valid_q;
  ssp_pkg::result_t out_q;

  logic [31:0]    n_eff;
  logic [XW-1:0]  l_ix, r_ix, hs_x;
  logic [31:0]    raw_sum;
  logic [DW-1:0]  sat_sum;
  logic           out_free;

  assign n_eff    = (32'(node_count_i) > 32'(MAX_NODES)) ? 32'(MAX_NODES)
                                                          : 32'(node_count_i);
  assign l_ix     = (XW'(hi_q) << 1) + XW'(1);
  assign r_ix     = l_ix + XW'(1);
  assign hs_x     = XW'(hsize_q);
  assign raw_sum  = {1'b0, du_q} + {2'b0, edge_rd.length};
  assign sat_sum  = (raw_sum > 32'(ssp_pkg::UNREACH)) ? ssp_pkg::UNREACH : raw_sum[DW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  assign init_busy_o  = (st_q == S_INIT);
  assign task_ready_o = (st_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  // sequencer
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    task_d   = task_q;
    ecount_d = ecount_q;
    hsize_d  = hsize_q;
    hi_d     = hi_q;
    top_d    = top_q;
    cur_d    = cur_q;
    lch_d    = lch_q;
    du_d     = du_q;
    link_d   = link_q;
    sum_d    = sum_q;
    v_d      = v_q;
    res_d    = res_q;

    fe_we   = 1'b0;
    fe_wa   = cnt_q;
    fe_wd   = NULL_EDGE;
    fe_ra   = NIW'(task_i.from_node);
    dist_we = 1'b0;
    dist_wa = cnt_q;
    dist_wd = '{done: 1'b0, dval: ssp_pkg::UNREACH};
    dist_ra = NIW'(task_i.query_node);
    edge_we = 1'b0;
    edge_wa = EAW'(ecount_q);
    edge_wd = '{target: task_q.to_node, length: task_q.weight, link: fe_rd};
    edge_ra = EAW'(link_q);
    heap_we = 1'b0;
    heap_wa = hi_q;
    heap_wd = cur_q;
    heap_ra = '0;

    unique case (st_q)
      // clear after reset: edge heads null, distances unreachable
      S_INIT: begin
        fe_we   = 1'b1;
        dist_we = 1'b1;
        cnt_d   = cnt_q + NIW'(1);
        if (cnt_q == NIW'(MAX_NODES)) begin
          cnt_d = '0;
          st_d  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (task_valid_i) begin
          task_d = task_i;
          unique case (task_i.kind)
            ssp_pkg::KIND_ADD: begin
              if (task_i.bad) begin
                res_d = '{distance: '0, status: ssp_pkg::STAT_RANGE};
                st_d  = S_DONE;
              end else if (ecount_q == NULL_EDGE) begin
                res_d = '{distance: '0, status: ssp_pkg::STAT_FULL};
                st_d  = S_DONE;
              end else begin
                st_d = S_ADD_WR;
              end
            end
            ssp_pkg::KIND_READ: begin
              if (task_i.bad) begin
                res_d = '{distance: ssp_pkg::UNREACH, status: ssp_pkg::STAT_RANGE};
                st_d  = S_DONE;
              end else begin
                st_d = S_READ_WB;
              end
            end
            ssp_pkg::KIND_RUN: begin
              cnt_d   = '0;
              hsize_d = '0;
              st_d    = S_CLR;
            end
            default: begin
              res_d = '{distance: '0, status: ssp_pkg::STAT_OK};
              st_d  = S_DONE;
            end
          endcase
        end
      end
      // link the new edge in front of its node's list
      S_ADD_WR: begin
        edge_we  = 1'b1;
        fe_we    = 1'b1;
        fe_wa    = NIW'(task_q.from_node);
        fe_wd    = ecount_q;
        ecount_d = ecount_q + EIW'(1);
        res_d    = '{distance: '0, status: ssp_pkg::STAT_OK};
        st_d     = S_DONE;
      end
      S_READ_WB: begin
        res_d = '{distance: dist_rd.dval, status: ssp_pkg::STAT_OK};
        st_d  = S_DONE;
      end
      // clear distances and settled flags for a run
      S_CLR: begin
        dist_we = 1'b1;
        cnt_d   = cnt_q + NIW'(1);
        if (cnt_q == NIW'(MAX_NODES)) begin
          cnt_d = '0;
          if (task_q.bad) begin
            res_d = '{distance: '0, status: ssp_pkg::STAT_RANGE};
            st_d  = S_DONE;
          end else begin
            st_d = S_SRC;
          end
        end
      end
      S_SRC: begin
        dist_we = 1'b1;
        dist_wa = NIW'(source_node_i);
        dist_wd = '{done: 1'b0, dval: '0};
        heap_we = 1'b1;
        heap_wa = '0;
        heap_wd = '{node: source_node_i, key: '0};
        hsize_d = HIW'(1);
        st_d    = S_POP0;
      end
      // pop the least key
      S_POP0: begin
        heap_ra = '0;
        if (hsize_q == '0) begin
          res_d = '{distance: '0, status: ssp_pkg::STAT_OK};
          st_d  = S_DONE;
        end else begin
          st_d = S_POP1;
        end
      end
      S_POP1: begin
        top_d   = heap_rd.node;
        heap_ra = HAW'(hsize_q - HIW'(1));
        st_d    = S_POP2;
      end
      S_POP2: begin
        cur_d   = heap_rd;
        hsize_d = hsize_q - HIW'(1);
        hi_d    = '0;
        st_d    = S_SD0;
      end
      // sift the moved element down, one level per pass
      S_SD0: begin
        heap_ra = HAW'(l_ix);
        if (l_ix >= hs_x) begin
          heap_we = (hsize_q != '0);
          st_d    = S_SET_RD;
        end else begin
          st_d = S_SD1;
        end
      end
      S_SD1: begin
        lch_d   = heap_rd;
        heap_ra = HAW'(r_ix);
        if (r_ix < hs_x) begin
          st_d = S_SD2;
        end else if (heap_rd.key < cur_q.key) begin
          heap_we = 1'b1;
          heap_wd = heap_rd;
          hi_d    = HAW'(l_ix);
          st_d    = S_SD0;
        end else begin
          heap_we = 1'b1;
          st_d    = S_SET_RD;
        end
      end
      S_SD2: begin
        heap_we = 1'b1;
        if (lch_q.key < cur_q.key) begin
          if (heap_rd.key < lch_q.key) begin
            heap_wd = heap_rd;
            hi_d    = HAW'(r_ix);
          end else begin
            heap_wd = lch_q;
            hi_d    = HAW'(l_ix);
          end
          st_d = S_SD0;
        end else if (heap_rd.key < cur_q.key) begin
          heap_wd = heap_rd;
          hi_d    = HAW'(r_ix);
          st_d    = S_SD0;
        end else begin
          st_d = S_SET_RD;
        end
      end
      // skip nodes already settled
      S_SET_RD: begin
        dist_ra = NIW'(top_q);
        st_d    = S_SET_CHK;
      end
      S_SET_CHK: begin
        fe_ra = NIW'(top_q);
        if (dist_rd.done) begin
          st_d = S_POP0;
        end else begin
          dist_we = 1'b1;
          dist_wa = NIW'(top_q);
          dist_wd = '{done: 1'b1, dval: dist_rd.dval};
          du_d    = dist_rd.dval;
          st_d    = S_FE;
        end
      end
      S_FE: begin
        edge_ra = EAW'(fe_rd);
        if (fe_rd == NULL_EDGE) begin
          st_d = S_POP0;
        end else begin
          st_d = S_EDGE;
        end
      end
      // relax one outgoing edge
      S_EDGE: begin
        v_d     = edge_rd.target;
        sum_d   = sat_sum;
        link_d  = edge_rd.link;
        dist_ra = NIW'(edge_rd.target);
        edge_ra = EAW'(edge_rd.link);
        if ((edge_rd.target == '0) || (32'(edge_rd.target) > n_eff)) begin
          st_d = (edge_rd.link == NULL_EDGE) ? S_POP0 : S_EDGE;
        end else begin
          st_d = S_DST;
        end
      end
      S_DST: begin
        if (dist_rd.dval > sum_q) begin
          dist_we = 1'b1;
          dist_wa = NIW'(v_q);
          dist_wd = '{done: dist_rd.done, dval: sum_q};
          hi_d    = HAW'(hsize_q);
          hsize_d = hsize_q + HIW'(1);
          st_d    = S_PU0;
        end else begin
          st_d = (link_q == NULL_EDGE) ? S_POP0 : S_EDGE;
        end
      end
      // push: sift the new element up
      S_PU0: begin
        heap_ra = HAW'((hi_q - HAW'(1)) >> 1);
        if (hi_q == '0) begin
          heap_we = 1'b1;
          heap_wd = '{node: v_q, key: sum_q};
          st_d    = (link_q == NULL_EDGE) ? S_POP0 : S_EDGE;
        end else begin
          st_d = S_PU1;
        end
      end
      S_PU1: begin
        heap_we = 1'b1;
        if (heap_rd.key <= sum_q) begin
          heap_wd = '{node: v_q, key: sum_q};
          st_d    = (link_q == NULL_EDGE) ? S_POP0 : S_EDGE;
        end else begin
          heap_wd = heap_rd;
          hi_d    = HAW'((hi_q - HAW'(1)) >> 1);
          st_d    = S_PU0;
        end
      end
      S_DONE: begin
        if (out_free) st_d = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_INIT;
      cnt_q       <= '0;
      ecount_q    <= '0;
      hsize_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      ecount_q <= ecount_d;
      hsize_q  <= hsize_d;
      if ((st_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    hi_q   <= hi_d;
    top_q  <= top_d;
    cur_q  <= cur_d;
    lch_q  <= lch_d;
    du_q   <= du_d;
    link_q <= link_d;
    sum_q  <= sum_d;
    v_q    <= v_d;
    res_q  <= res_d;
    if ((st_q == S_DONE) && out_free) out_q <= res_q;
  end

endmodule
